[sv/dbps_pkg.sv]
package dbps_pkg;

  // register file layout
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DutyW    = 16;
  localparam int unsigned PreW     = 4;
  localparam int unsigned PreCntW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PWM_PERIOD    = 3'd0,
    CFG_DUTY_STEP     = 3'd1,
    CFG_DUTY_INITIAL  = 3'd2,
    CFG_LOCKOUT_TICKS = 3'd3,
    CFG_PWM_PRESCALE  = 3'd4
  } cfg_idx_e;

  // reset values of the registers
  localparam logic [DutyW-1:0] PwmPeriodRst    = 16'd1000;
  localparam logic [DutyW-1:0] DutyStepRst     = 16'd100;
  localparam logic [DutyW-1:0] DutyInitialRst  = 16'd500;
  localparam logic [DutyW-1:0] LockoutTicksRst = 16'd10000;
  localparam logic [PreW-1:0]  PwmPrescaleRst  = 4'd2;

  // prescaler divide limits
  localparam logic [PreW-1:0] PreMin = 4'd1;
  localparam logic [PreW-1:0] PreMax = 4'd8;

  typedef struct packed {
    logic [DutyW-1:0] pwm_period;
    logic [DutyW-1:0] duty_step;
    logic [DutyW-1:0] duty_initial;
    logic [DutyW-1:0] lockout_ticks;
    logic [PreW-1:0]  pwm_prescale;
  } cfg_t;

  typedef struct packed {
    logic             pwm_out;
    logic             indicator;
    logic [DutyW-1:0] duty_level;
    logic             button_armed;
  } result_t;

endpackage

[sv/dbps_cfg.sv]
module dbps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  output dbps_pkg::cfg_t                cfg_o,
  output logic                          duty_ld_o
);
  import dbps_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period    <= PwmPeriodRst;
      cfg_q.duty_step     <= DutyStepRst;
      cfg_q.duty_initial  <= DutyInitialRst;
      cfg_q.lockout_ticks <= LockoutTicksRst;
      cfg_q.pwm_prescale  <= PwmPrescaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_PERIOD:    cfg_q.pwm_period    <= cfg_wdata_i;
        CFG_DUTY_STEP:     cfg_q.duty_step     <= cfg_wdata_i;
        CFG_DUTY_INITIAL:  cfg_q.duty_initial  <= cfg_wdata_i;
        CFG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= cfg_wdata_i;
        CFG_PWM_PRESCALE:  cfg_q.pwm_prescale  <= cfg_wdata_i[PreW-1:0];
        default: ;
      endcase
    end
  end

  // a write of the initial duty also reloads the live duty
  assign duty_ld_o = cfg_we_i && (cfg_idx_i == CFG_DUTY_INITIAL);
  assign cfg_o     = cfg_q;

endmodule

[sv/dbps_tick.sv]
module dbps_tick #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         level_i,
  input  dbps_pkg::cfg_t               cfg_i,
  input  logic                         duty_ld_i,
  input  logic [dbps_pkg::DutyW-1:0]   duty_ld_val_i,
  output dbps_pkg::result_t            res_o
);
  import dbps_pkg::*;

  localparam int unsigned CmpW = (COUNT_WIDTH > DutyW) ? COUNT_WIDTH : DutyW;

  logic [COUNT_WIDTH-1:0] pwm_cnt_q, pwm_cnt_d;
  logic [COUNT_WIDTH-1:0] lock_cnt_q, lock_cnt_d;
  logic [PreCntW-1:0]     pre_cnt_q, pre_cnt_d;
  logic [DutyW-1:0]       duty_q, duty_d;
  logic                   armed_q, armed_d;
  logic                   exp_fall_q, exp_fall_d;
  logic                   last_lvl_q, last_lvl_d;
  logic                   led_q, led_d;

  logic                   falling, rising, hit;
  logic [DutyW:0]         duty_sum;
  logic [PreW-1:0]        div;
  logic [PreW-1:0]        pre_next;
  logic [CmpW-1:0]        pwm_cnt_x, pwm_cnt_dx, period_x, lock_cnt_x, lock_ticks_x, duty_dx;

  // operands widened to a common compare width
  assign pwm_cnt_x    = CmpW'(pwm_cnt_q);
  assign pwm_cnt_dx   = CmpW'(pwm_cnt_d);
  assign period_x     = CmpW'(cfg_i.pwm_period);
  assign lock_cnt_x   = CmpW'(lock_cnt_q);
  assign lock_ticks_x = CmpW'(cfg_i.lockout_ticks);
  assign duty_dx      = CmpW'(duty_d);

  // edge detect against the previous level
  assign falling  = last_lvl_q && !level_i;
  assign rising   = !last_lvl_q && level_i;
  assign hit      = exp_fall_q ? falling : rising;
  assign duty_sum = {1'b0, duty_q} + {1'b0, cfg_i.duty_step};

  // clamp prescale to 1..8
  always_comb begin
    if (cfg_i.pwm_prescale < PreMin) begin
      div = PreMin;
    end else if (cfg_i.pwm_prescale > PreMax) begin
      div = PreMax;
    end else begin
      div = cfg_i.pwm_prescale;
    end
  end

  assign pre_next = {1'b0, pre_cnt_q} + PreW'(1);

  // next state for one tick
  always_comb begin
    pwm_cnt_d  = pwm_cnt_q;
    lock_cnt_d = lock_cnt_q;
    pre_cnt_d  = pre_cnt_q;
    duty_d     = duty_q;
    armed_d    = armed_q;
    exp_fall_d = exp_fall_q;
    last_lvl_d = last_lvl_q;
    led_d      = led_q;

    if (adv_i) begin
      // button: accept the expected edge or run the lockout
      if (armed_q) begin
        if (hit) begin
          if (exp_fall_q) begin
            if (duty_q < cfg_i.pwm_period) begin
              duty_d = duty_sum[DutyW] ? {DutyW{1'b1}} : duty_sum[DutyW-1:0];
            end else begin
              duty_d = '0;
            end
          end
          exp_fall_d = !exp_fall_q;
          led_d      = !led_q;
          armed_d    = 1'b0;
          lock_cnt_d = '0;
        end
      end else begin
        if (lock_cnt_x >= lock_ticks_x) begin
          armed_d    = 1'b1;
          lock_cnt_d = '0;
        end else begin
          lock_cnt_d = lock_cnt_q + COUNT_WIDTH'(1);
        end
      end
      last_lvl_d = level_i;

      // prescaler and pwm counter
      if (pre_next >= div) begin
        pre_cnt_d = '0;
        if (pwm_cnt_x >= period_x) begin
          pwm_cnt_d = '0;
        end else begin
          pwm_cnt_d = pwm_cnt_q + COUNT_WIDTH'(1);
        end
      end else begin
        pre_cnt_d = pre_next[PreCntW-1:0];
      end
    end

    if (duty_ld_i) begin
      duty_d = duty_ld_val_i;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_cnt_q  <= '0;
      lock_cnt_q <= '0;
      pre_cnt_q  <= '0;
      duty_q     <= DutyInitialRst;
      armed_q    <= 1'b1;
      exp_fall_q <= 1'b1;
      last_lvl_q <= 1'b1;
      led_q      <= 1'b0;
    end else begin
      pwm_cnt_q  <= pwm_cnt_d;
      lock_cnt_q <= lock_cnt_d;
      pre_cnt_q  <= pre_cnt_d;
      duty_q     <= duty_d;
      armed_q    <= armed_d;
      exp_fall_q <= exp_fall_d;
      last_lvl_q <= last_lvl_d;
      led_q      <= led_d;
    end
  end

  // result shows the state after this tick
  assign res_o.pwm_out      = pwm_cnt_dx < duty_dx;
  assign res_o.indicator    = led_d;
  assign res_o.duty_level   = duty_d;
  assign res_o.button_armed = armed_d;

endmodule

[sv/debounced_button_pwm_duty_stepper_core.sv]
// Push-button PWM duty stepper. Each input beat is one tick carrying the raw
// level of a pulled-up button; each tick yields exactly one result beat with
// the PWM output, indicator, current duty and armed flag as they stand after
// that tick. One beat is accepted per clock cycle unless the input side
// stalls; a beat passes through an input register and the tick logic into a
// result register, from which its result is offered. The input side stalls
// only while both the input register and the result register are full and
// the result beat is stalled. Configuration writes take effect at the write
// edge and must be made with no beat in flight; writing the initial duty also
// reloads the live duty.
module debounced_button_pwm_duty_stepper_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          button_level_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pwm_out_o,
  output logic                          indicator_o,
  output logic [dbps_pkg::DutyW-1:0]    duty_level_o,
  output logic                          button_armed_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [dbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dbps_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import dbps_pkg::*;

  cfg_t    cfg;
  logic    duty_ld;
  result_t res_d, res_q;

  logic in_valid_q, in_valid_d;
  logic level_q;
  logic out_valid_q;
  logic out_ready, adv, in_accept;

  dbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .duty_ld_o   (duty_ld)
  );

  // handshake between the two register stages
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= button_level_i;
    end
  end

  dbps_tick #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .level_i       (level_q),
    .cfg_i         (cfg),
    .duty_ld_i     (duty_ld),
    .duty_ld_val_i (cfg_wdata_i),
    .res_o         (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_out_o      = res_q.pwm_out;
  assign indicator_o    = res_q.indicator;
  assign duty_level_o   = res_q.duty_level;
  assign button_armed_o = res_q.button_armed;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dbps_pkg::*;

  // clock, reset and block ports
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic                button_level_i = 1'b1;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                pwm_out_o;
  logic                indicator_o;
  logic [DutyW-1:0]    duty_level_o;
  logic                button_armed_o;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;

  debounced_button_pwm_duty_stepper_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pwm_out_o      (pwm_out_o),
    .indicator_o    (indicator_o),
    .duty_level_o   (duty_level_o),
    .button_armed_o (button_armed_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  int errors = 0;

  // idle rates in percent, and receiver hold-off requests
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len      = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // register mirror
  logic [DutyW-1:0] p_period = PwmPeriodRst;
  logic [DutyW-1:0] p_step   = DutyStepRst;
  logic [DutyW-1:0] p_init   = DutyInitialRst;
  logic [DutyW-1:0] p_lock   = LockoutTicksRst;
  logic [PreW-1:0]  p_pre    = PwmPrescaleRst;

  // tick state mirror
  logic [15:0]        m_pwm_cnt  = '0;
  logic [PreCntW-1:0] m_pre_cnt  = '0;
  logic [DutyW-1:0]   m_duty     = DutyInitialRst;
  logic               m_armed    = 1'b1;
  logic               m_want_fall = 1'b1;
  logic [15:0]        m_lock_cnt = '0;
  logic               m_last_lvl = 1'b1;
  logic               m_led      = 1'b0;

  result_t due_results[$];
  result_t want_res;

  // advance the mirrored state by one tick and queue the beat it yields
  task automatic compute_tick(input logic lvl);
    logic        fall;
    logic        rise;
    logic        hit;
    logic [16:0] sum;
    int          div;
    result_t     r;
    fall = m_last_lvl & ~lvl;
    rise = ~m_last_lvl & lvl;
    // edge detection and debounce lockout
    if (m_armed) begin
      hit = m_want_fall ? fall : rise;
      if (hit) begin
        if (m_want_fall) begin
          if (m_duty < p_period) begin
            sum = {1'b0, m_duty} + {1'b0, p_step};
            m_duty = sum[16] ? {DutyW{1'b1}} : sum[DutyW-1:0];
          end else begin
            m_duty = '0;
          end
        end
        m_want_fall = ~m_want_fall;
        m_led = ~m_led;
        m_armed = 1'b0;
        m_lock_cnt = '0;
      end
    end else if (m_lock_cnt >= p_lock) begin
      m_armed = 1'b1;
      m_lock_cnt = '0;
    end else begin
      m_lock_cnt = m_lock_cnt + 1'b1;
    end
    m_last_lvl = lvl;
    // prescaler and pwm counter
    div = int'(p_pre);
    if (div < int'(PreMin)) div = int'(PreMin);
    if (div > int'(PreMax)) div = int'(PreMax);
    if (int'(m_pre_cnt) + 1 >= div) begin
      m_pre_cnt = '0;
      if (m_pwm_cnt >= p_period) m_pwm_cnt = '0;
      else m_pwm_cnt = m_pwm_cnt + 1'b1;
    end else begin
      m_pre_cnt = m_pre_cnt + 1'b1;
    end
    r.pwm_out      = (m_pwm_cnt < m_duty);
    r.indicator    = m_led;
    r.duty_level   = m_duty;
    r.button_armed = m_armed;
    due_results.push_back(r);
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker: each accepted beat against the oldest due one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t ns: result beat with nothing due, expected none got duty %0d",
                 $time, duty_level_o);
        errors++;
      end else begin
        want_res = due_results.pop_front();
        report_field("pwm_out", 16'(want_res.pwm_out), 16'(pwm_out_o));
        report_field("indicator", 16'(want_res.indicator), 16'(indicator_o));
        report_field("duty_level", want_res.duty_level, duty_level_o);
        report_field("button_armed", 16'(want_res.button_armed), 16'(button_armed_o));
      end
    end
  end

  // receiver stall: random idling or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // send one tick beat, with random idle cycles ahead of it
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    compute_tick(lvl);
  endtask

  // levels sent from the msb of the pattern down
  task automatic send_pattern(input logic [15:0] pat, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(pat[i]);
  endtask

  // stop sending and wait until every due beat has come
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PWM_PERIOD:    p_period = data;
      CFG_DUTY_STEP:     p_step = data;
      CFG_DUTY_INITIAL: begin
        p_init = data;
        m_duty = data;
      end
      CFG_LOCKOUT_TICKS: p_lock = data;
      CFG_PWM_PRESCALE:  p_pre = data[PreW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [15:0] per, input logic [15:0] stp,
                           input logic [15:0] ini, input logic [15:0] lck,
                           input logic [15:0] pre);
    cfg_write(CFG_PWM_PERIOD, per);
    cfg_write(CFG_DUTY_STEP, stp);
    cfg_write(CFG_DUTY_INITIAL, ini);
    cfg_write(CFG_LOCKOUT_TICKS, lck);
    cfg_write(CFG_PWM_PRESCALE, pre);
    cfg_close();
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // mostly clean press/release runs, some contact bounce
  task automatic send_random_ticks(input int n, input int lock);
    int sent;
    int run;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        run = $urandom_range(1, lock + 4);
        repeat (run) send_tick(1'b1);
        sent += run;
        run = $urandom_range(1, lock + 4);
        repeat (run) send_tick(1'b0);
        sent += run;
      end else begin
        run = $urandom_range(2, 8);
        repeat (run) send_tick(1'($urandom_range(0, 1)));
        sent += run;
      end
    end
  endtask

  // default registers: one press, then the long lockout
  task automatic test_reset_values;
    send_pattern(16'b110, 3);
  endtask

  // short period, no lockout: edge on the re-arm tick, duty past period, wrap
  task automatic test_wrap_and_rearm;
    drain();
    apply_cfg(16'd3, 16'd2, 16'd0, 16'd0, 16'd1);
    send_pattern(16'b1011011010, 10);
  endtask

  // duty saturation at full scale, prescale above the max
  task automatic test_saturation;
    drain();
    apply_cfg(16'hFFFF, 16'hFFFF, 16'd65000, 16'd0, 16'd15);
    send_pattern(16'b1011010, 7);
  endtask

  // zero period, edges inside lockout, ignored indexes, masked prescale
  task automatic test_period_zero_and_masking;
    drain();
    apply_cfg(16'd0, 16'd5, 16'd7, 16'd2, 16'd0);
    for (int k = int'(CFG_PWM_PRESCALE) + 1; k < (1 << CfgIdxW); k++)
      cfg_write(CfgIdxW'(k), {CfgDataW{1'b1}});
    cfg_write(CFG_PWM_PRESCALE, 16'hFFF0);
    cfg_close();
    send_pattern(16'b10101110, 8);
  endtask

  // rounds of fresh random settings, each followed by random button activity
  task automatic test_random_rounds(input int rounds, input int n);
    logic [15:0] per;
    logic [15:0] stp;
    logic [15:0] ini;
    logic [15:0] lck;
    for (int r = 0; r < rounds; r++) begin
      drain();
      case ($urandom_range(0, 5))
        0: per = 16'hFFFF;
        1: per = 16'd1;
        default: per = 16'($urandom_range(2, 64));
      endcase
      stp = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 24));
      ini = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 70));
      lck = 16'($urandom_range(0, 12));
      apply_cfg(per, stp, ini, lck, 16'($urandom_range(0, 15)));
      send_random_ticks(n, int'(lck));
    end
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure;
    drain();
    apply_cfg(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd8);
    set_idling(0, 0);
    hold_len = 48;
    hold_reqs++;
    send_random_ticks(70, 6);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(28, 75);
    test_reset_values();
    test_wrap_and_rearm();
    test_saturation();
    test_period_zero_and_masking();
    test_random_rounds(3, 30);
    set_idling(75, 28);
    test_random_rounds(3, 30);
    set_idling(0, 0);
    test_random_rounds(3, 30);
    test_backpressure();
    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
